### src/gbgfi_pkg.sv
// Shared constants, types and divide-by-constant helpers for the ice grid interpolator.
package gbgfi_pkg;

	// Default grid geometry
	localparam int GRID_COLS_DEF = 1440;
	localparam int GRID_ROWS_DEF = 720;

	// Angular spans in 1/1024-degree units
	localparam int LON_SPAN = 368640;
	localparam int LAT_SPAN = 184320;
	localparam int HALF_LON = 184320;
	localparam int HALF_LAT = 92160;
	// Longitude bias: half a turn plus one full turn keeps the position positive
	localparam int LON_BIAS = 552960;
	localparam int LAT_BIAS = 92160;
	// Largest biased longitude that the 19-bit input can carry
	localparam longint LON_B_MAX = 815103;

	// Storage layout
	localparam int ADDR_W = 22;
	localparam int VAL_W  = 16;
	localparam int CELL_W = 17;

	// Request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic CFG_THRESHOLD  = 1'b0;
	localparam logic CFG_GRID_READY = 1'b1;

	// Reciprocal constants for exact floor division on bounded inputs
	localparam logic [24:0] DIV45_MUL = 25'd23860930;
	localparam logic [18:0] DIV3_MUL  = 19'd349526;

	// Control carried through the address pipeline
	typedef struct packed {
		logic              query;
		logic              no_data;
		logic              wr_ok;
		logic [CELL_W-1:0] wdata;
	} ctl_t;

	// Memory access and weights leaving the address pipeline
	typedef struct packed {
		logic                   valid;
		logic                   no_data;
		logic                   wr_en;
		logic [CELL_W-1:0]      wdata;
		logic [3:0][ADDR_W-1:0] addr;
		logic [7:0]             t;
		logic [7:0]             u;
	} geo_t;

	// One finished result
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] frac;
		logic             flag;
		logic             no_data;
	} res_t;

	// Floor of x / 45, exact for x below 2^20
	function automatic logic [14:0] div45(input logic [19:0] x);
		logic [44:0] p;
		p = x * DIV45_MUL;
		return p[44:30];
	endfunction

	// Floor of x / 3, exact for x below 2^18
	function automatic logic [17:0] div3(input logic [17:0] x);
		logic [36:0] p;
		p = x * DIV3_MUL;
		return p[37-1:20] > 0 ? 18'(p[36:20]) : 18'd0;
	endfunction

endpackage

### src/gbgfi_if.sv
// Request and result channel interfaces of the ice grid interpolator.
interface gbgfi_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [9:0]         cell_row;
	logic [10:0]        cell_col;
	logic [15:0]        cell_value;
	logic               cell_missing;
	logic signed [18:0] query_lon;
	logic signed [17:0] query_lat;

	modport source (output valid, opcode, cell_row, cell_col, cell_value, cell_missing,
		query_lon, query_lat, input ready);
	modport sink (input valid, opcode, cell_row, cell_col, cell_value, cell_missing,
		query_lon, query_lat, output ready);
endinterface

interface gbgfi_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] cover_frac;
	logic        ice_flag;
	logic        no_data;

	modport source (output valid, cover_frac, ice_flag, no_data, input ready);
	modport sink (input valid, cover_frac, ice_flag, no_data, output ready);
endinterface

### src/gbgfi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gbgfi_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; hold data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### src/gbgfi_geom.sv
// Address pipeline: locates the four corner cells and the bilinear weights of a query.
module gbgfi_geom #(
	parameter int GRID_COLS = gbgfi_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gbgfi_pkg::GRID_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               acc,
	input  logic               opcode,
	input  logic [9:0]         cell_row,
	input  logic [10:0]        cell_col,
	input  logic [15:0]        cell_value,
	input  logic               cell_missing,
	input  logic signed [18:0] query_lon,
	input  logic signed [17:0] query_lat,
	input  logic               grid_ready,
	output gbgfi_pkg::geo_t    geo
);
	import gbgfi_pkg::*;

	localparam int CW = $clog2(GRID_COLS);
	localparam int RW = $clog2(GRID_ROWS);
	localparam longint PMAX = LON_B_MAX * GRID_COLS + HALF_LON;
	localparam int PW = $clog2(PMAX + 1);
	localparam longint EMAX = PMAX / LON_SPAN;
	localparam int EW = $clog2(EMAX + 1);
	localparam longint QMAX = longint'(GRID_ROWS + 1) * LAT_SPAN - 1;
	localparam int QW = $clog2(QMAX + 1);
	localparam int GW = $clog2(GRID_ROWS + 1);
	localparam logic signed [33:0] ROWS_S = 34'(GRID_ROWS);
	localparam logic signed [33:0] HLAT_S = 34'(HALF_LAT);
	localparam logic signed [33:0] QMAX_S = 34'(QMAX);

	// Stage 1: scaled positions
	logic [19:0]        lon_b;
	logic signed [19:0] lat_b;
	logic signed [33:0] q_full;
	logic [PW-1:0]      p_c;
	logic [QW-1:0]      q_c;
	ctl_t               ctl_c;

	logic              v_s1, v_s2, v_s3, v_s4;
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [PW-1:0]     p_s1, p_s2;
	logic [QW-1:0]     q_s1, q_s2;
	logic [RW-1:0]     wrow_s1, wrow_s2;
	logic [CW-1:0]     wcol_s1, wcol_s2;
	logic [EW-1:0]     e_s2;
	logic [GW-1:0]     g_s2;
	logic [18:0]       fx_s3;
	logic [17:0]       fy_s3;
	logic [RW-1:0]     rl_s3, ru_s3;
	logic [CW-1:0]     cl_s3, cr_s3;
	logic [ADDR_W-1:0] bl_s4, bu_s4;
	logic [CW-1:0]     cl_s4, cr_s4;
	logic [7:0]        t_s4, u_s4;

	function automatic logic [CW-1:0] wrap_col(input logic [EW-1:0] v);
		if (v < GRID_COLS) begin
			return CW'(v);
		end else if (v < 2 * GRID_COLS) begin
			return CW'(v - GRID_COLS);
		end
		return CW'(v - 2 * GRID_COLS);
	endfunction

	always_comb begin
		lon_b  = 20'(int'(query_lon) + LON_BIAS);
		lat_b  = 20'(int'(query_lat) + LAT_BIAS);
		p_c    = PW'(64'(lon_b) * GRID_COLS + HALF_LON);
		q_full = lat_b * ROWS_S + HLAT_S;
		if (q_full < 0) begin
			q_c = '0;
		end else if (q_full > QMAX_S) begin
			q_c = QW'(QMAX);
		end else begin
			q_c = QW'(q_full);
		end
		ctl_c.query   = (opcode == OP_QUERY);
		ctl_c.no_data = !grid_ready;
		ctl_c.wr_ok   = (opcode == OP_WRITE) && (int'(cell_row) < GRID_ROWS)
			&& (int'(cell_col) < GRID_COLS);
		ctl_c.wdata   = {cell_missing, cell_value};
	end

	// Stage 3 combinational: fractions and corner indexes
	logic [EW-1:0] em1;
	logic [18:0]   fx_c;
	logic [17:0]   fy_c;
	logic [RW-1:0] rl_c, ru_c;
	logic [CW-1:0] cl_c, cr_c;

	always_comb begin
		em1  = e_s2 - 1'b1;
		fx_c = 19'(p_s2 - PW'(64'(e_s2) * LON_SPAN));
		fy_c = 18'(q_s2 - QW'(64'(g_s2) * LAT_SPAN));
		ru_c = (int'(g_s2) >= GRID_ROWS) ? RW'(GRID_ROWS - 1) : RW'(g_s2);
		cr_c = wrap_col(e_s2);
		// Writes reuse the lower-left slot for their own cell
		if (ctl_s2.query) begin
			rl_c = (g_s2 == '0) ? '0 : RW'(g_s2 - 1'b1);
			cl_c = wrap_col(em1);
		end else begin
			rl_c = wrow_s2;
			cl_c = wcol_s2;
		end
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_c;
			p_s1    <= p_c;
			q_s1    <= q_c;
			wrow_s1 <= RW'(cell_row);
			wcol_s1 <= CW'(cell_col);

			ctl_s2  <= ctl_s1;
			p_s2    <= p_s1;
			q_s2    <= q_s1;
			wrow_s2 <= wrow_s1;
			wcol_s2 <= wcol_s1;
			e_s2    <= EW'(div45(20'(p_s1 >> 13)));
			g_s2    <= GW'(div45(20'(q_s1 >> 12)));

			ctl_s3 <= ctl_s2;
			fx_s3  <= fx_c;
			fy_s3  <= fy_c;
			rl_s3  <= rl_c;
			ru_s3  <= ru_c;
			cl_s3  <= cl_c;
			cr_s3  <= cr_c;

			ctl_s4 <= ctl_s3;
			bl_s4  <= ADDR_W'(32'(rl_s3) * GRID_COLS);
			bu_s4  <= ADDR_W'(32'(ru_s3) * GRID_COLS);
			cl_s4  <= cl_s3;
			cr_s4  <= cr_s3;
			t_s4   <= 8'(div45(20'(fx_s3 >> 5)));
			u_s4   <= 8'(div45(20'(fy_s3 >> 4)));
		end
	end

	// Corner addresses: lower-left, lower-right, upper-right, upper-left
	always_comb begin
		geo.valid   = v_s4 && ctl_s4.query;
		geo.no_data = ctl_s4.no_data;
		geo.wr_en   = v_s4 && ctl_s4.wr_ok;
		geo.wdata   = ctl_s4.wdata;
		geo.addr[0] = bl_s4 + ADDR_W'(cl_s4);
		geo.addr[1] = bl_s4 + ADDR_W'(cr_s4);
		geo.addr[2] = bu_s4 + ADDR_W'(cr_s4);
		geo.addr[3] = bu_s4 + ADDR_W'(cl_s4);
		geo.t       = t_s4;
		geo.u       = u_s4;
	end
endmodule

### src/gbgfi_blend.sv
// Blend pipeline: fills missing corners with the valid mean and interpolates bilinearly.
module gbgfi_blend (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  gbgfi_pkg::geo_t                         geo,
	input  logic [3:0][gbgfi_pkg::CELL_W-1:0]       rdata,
	input  logic [gbgfi_pkg::VAL_W-1:0]             threshold,
	output gbgfi_pkg::res_t                         res
);
	import gbgfi_pkg::*;

	logic             qv_s5, qv_s6, qv_s7, qv_s8;
	logic             nd_s5, nd_s6, nd_s7, nd_s8;
	logic [7:0]       t_s5, u_s5;
	logic [3:0]       miss_s6;
	logic [3:0][15:0] val_s6;
	logic [17:0]      sum_s6;
	logic [2:0]       cnt_s6;
	logic [3:0][16:0] w_s6, w_s7;
	logic [3:0][15:0] v_s7;
	logic             empty_s7, empty_s8;
	logic [3:0][32:0] prod_s8;

	// Stage 5: gather valid corners and build weights
	logic [17:0]      sum_c;
	logic [2:0]       cnt_c;
	logic [8:0]       ti, ui;
	logic [3:0][16:0] w_c;

	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int k = 0; k < 4; k++) begin
			if (!rdata[k][CELL_W-1]) begin
				sum_c = sum_c + 18'(rdata[k][VAL_W-1:0]);
				cnt_c = cnt_c + 3'd1;
			end
		end
		ti     = 9'd256 - 9'(t_s5);
		ui     = 9'd256 - 9'(u_s5);
		w_c[0] = 17'(ti) * 17'(ui);
		w_c[1] = 17'(t_s5) * 17'(ui);
		w_c[2] = 17'(t_s5) * 17'(u_s5);
		w_c[3] = 17'(ti) * 17'(u_s5);
	end

	// Stage 6: mean of valid corners replaces the missing ones
	logic [17:0]      mean_c;
	logic [3:0][15:0] v_c;

	always_comb begin
		unique case (cnt_s6)
			3'd1:    mean_c = sum_s6;
			3'd2:    mean_c = sum_s6 >> 1;
			3'd3:    mean_c = div3(sum_s6);
			3'd4:    mean_c = sum_s6 >> 2;
			default: mean_c = '0;
		endcase
		for (int k = 0; k < 4; k++) begin
			v_c[k] = miss_s6[k] ? 16'(mean_c) : val_s6[k];
		end
	end

	// Stage 7: weighted products
	logic [3:0][32:0] prod_c;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			prod_c[k] = 33'(v_s7[k]) * 33'(w_s7[k]);
		end
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s5 <= 1'b0;
			qv_s6 <= 1'b0;
			qv_s7 <= 1'b0;
			qv_s8 <= 1'b0;
		end else if (en) begin
			qv_s5 <= geo.valid;
			qv_s6 <= qv_s5;
			qv_s7 <= qv_s6;
			qv_s8 <= qv_s7;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			nd_s5 <= geo.no_data;
			t_s5  <= geo.t;
			u_s5  <= geo.u;

			nd_s6 <= nd_s5;
			for (int k = 0; k < 4; k++) begin
				miss_s6[k] <= rdata[k][CELL_W-1];
				val_s6[k]  <= rdata[k][VAL_W-1:0];
			end
			sum_s6 <= sum_c;
			cnt_s6 <= cnt_c;
			w_s6   <= w_c;

			nd_s7    <= nd_s6;
			v_s7     <= v_c;
			w_s7     <= w_s6;
			empty_s7 <= (cnt_s6 == 3'd0);

			nd_s8    <= nd_s7;
			empty_s8 <= empty_s7;
			prod_s8  <= prod_c;
		end
	end

	// Final sum, scale and threshold
	logic [34:0] acc_c;

	always_comb begin
		acc_c = 35'(prod_s8[0]) + 35'(prod_s8[1]) + 35'(prod_s8[2]) + 35'(prod_s8[3]);
		res.valid   = qv_s8;
		res.no_data = nd_s8;
		res.frac    = (nd_s8 || empty_s8) ? '0 : acc_c[31:16];
		res.flag    = res.frac > threshold;
	end
endmodule

### src/grid_bilinear_gap_fill_interp_unit.sv
// Top level of the gap-filling bilinear ice grid interpolator.
// Usage: requests arrive on req. A write request (opcode 0) stores one cell,
// value and missing flag, and gives no result; out-of-range cells are dropped.
// A query request (opcode 1) gives one result on rsp: the Q0.15 ice fraction
// interpolated from the four surrounding cells, the threshold flag, and no_data
// when grid_ready is clear. Configuration writes (cfg_wr_en, cfg_index,
// cfg_data) set the flag threshold and grid_ready; the user must issue them
// only while no request is in flight, as the block does not enforce this.
// Throughput: one request per cycle while the skid register is empty; the grid
// lives in four RAM copies, one per corner, each read once a cycle, and the
// pipeline around them takes one request per stage.
// Reset clears the pipeline, output register and configuration; the grid
// content is kept and must be written before it is read.
// When rsp stalls, one more result lands in a skid register and req.ready then
// drops until the skid register drains.
module grid_bilinear_gap_fill_interp_unit #(
	parameter int GRID_COLS = gbgfi_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gbgfi_pkg::GRID_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_index,
	input  logic [gbgfi_pkg::VAL_W-1:0]  cfg_data,
	gbgfi_req_if.sink                    req,
	gbgfi_rsp_if.source                  rsp
);
	import gbgfi_pkg::*;

	localparam int DEPTH = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(DEPTH);

	logic               en;
	logic               acc;
	logic [VAL_W-1:0]   thresh_q;
	logic               grid_ready_q;
	geo_t               geo;
	logic [3:0][CELL_W-1:0] rdata;
	res_t               res;
	res_t               out_q, skid_q;
	logic               out_v_q, skid_v_q;

	// Pipeline advances while the skid register is empty
	assign en        = !skid_v_q;
	assign req.ready = en;
	assign acc       = req.valid && en;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= '0;
			grid_ready_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_THRESHOLD:  thresh_q     <= cfg_data;
				CFG_GRID_READY: grid_ready_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	gbgfi_geom #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.acc         (acc),
		.opcode      (req.opcode),
		.cell_row    (req.cell_row),
		.cell_col    (req.cell_col),
		.cell_value  (req.cell_value),
		.cell_missing(req.cell_missing),
		.query_lon   (req.query_lon),
		.query_lat   (req.query_lat),
		.grid_ready  (grid_ready_q),
		.geo         (geo)
	);

	// One grid copy per corner; every write goes to all copies
	for (genvar k = 0; k < 4; k++) begin : g_bank
		gbgfi_ram #(
			.WIDTH(CELL_W),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (en && geo.wr_en),
			.waddr(geo.addr[0][AW-1:0]),
			.wdata(geo.wdata),
			.re   (en),
			.raddr(geo.addr[k][AW-1:0]),
			.rdata(rdata[k])
		);
	end

	gbgfi_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.geo      (geo),
		.rdata    (rdata),
		.threshold(thresh_q),
		.res      (res)
	);

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (rsp.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (res.valid) begin
			if (!out_v_q || rsp.ready) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (rsp.ready) begin
				out_q <= skid_q;
			end
		end else if (res.valid) begin
			if (!out_v_q || rsp.ready) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.cover_frac = out_q.frac;
	assign rsp.ice_flag   = out_q.flag;
	assign rsp.no_data    = out_q.no_data;

	// Skid register only holds a result behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full with empty output register");

	// Skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !rsp.ready))
		else $error("skid register filled without a stall");

	// No-data results carry zero fraction and flag
	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.no_data) |-> (out_q.frac == '0 && !out_q.flag))
		else $error("no-data result with non-zero payload");

	// Flag agrees with the threshold
	a_flag_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.flag == (out_q.frac > thresh_q)))
		else $error("ice flag disagrees with threshold");
endmodule

### tb/testbench.sv
// Self-checking testbench for the gap-filling bilinear ice grid interpolator.
`timescale 1ns / 1ps

module testbench;
	import gbgfi_pkg::*;

	localparam int NCOLS      = GRID_COLS_DEF;
	localparam int NROWS      = GRID_ROWS_DEF;
	localparam int DRAIN_WAIT = 12;
	localparam int STALL_LIM  = 4000;
	localparam int HOLD_LEN   = 300;

	typedef struct {
		logic               opcode;
		logic [9:0]         row;
		logic [10:0]        col;
		logic [15:0]        value;
		logic               missing;
		logic signed [18:0] lon;
		logic signed [17:0] lat;
	} grid_req_t;

	typedef struct {
		logic [15:0] frac;
		logic        flag;
		logic        no_data;
	} ice_result_t;

	// Shadow copy of the grid and registers; predicts each query result
	class ice_grid_scoreboard;
		bit [16:0]   cells[int];
		bit [15:0]   threshold;
		bit          grid_on;
		ice_result_t expected_q[$];
		int          mismatches;

		function void set_register(logic idx, logic [15:0] d);
			if (idx == CFG_THRESHOLD)
				threshold = d;
			else
				grid_on = d[0];
		endfunction

		// Find the four corner cells (ll, lr, ur, ul) and the weights
		function void locate(input logic signed [18:0] lon, input logic signed [17:0] lat,
				output int crow[4], output int ccol[4], output longint t,
				output longint u);
			longint lonv, latv, p, e, fx, q, qmax, g, fy;
			int cl, cr, rl, ru;
			lonv = lon;
			latv = lat;
			p = (lonv + LON_SPAN / 2) * NCOLS + LON_SPAN / 2;
			e = p / LON_SPAN;
			fx = p % LON_SPAN;
			if (fx < 0) begin
				fx += LON_SPAN;
				e -= 1;
			end
			cl = int'((e - 1) % NCOLS);
			if (cl < 0) cl += NCOLS;
			cr = int'(e % NCOLS);
			if (cr < 0) cr += NCOLS;
			q = (latv + LAT_SPAN / 2) * NROWS + LAT_SPAN / 2;
			qmax = longint'(NROWS + 1) * LAT_SPAN - 1;
			if (q < 0) q = 0;
			if (q > qmax) q = qmax;
			g = q / LAT_SPAN;
			fy = q % LAT_SPAN;
			rl = (g - 1 < 0) ? 0 : (g - 1 > NROWS - 1) ? NROWS - 1 : int'(g - 1);
			ru = (g > NROWS - 1) ? NROWS - 1 : int'(g);
			t = fx * 256 / LON_SPAN;
			u = fy * 256 / LAT_SPAN;
			crow = '{rl, rl, ru, ru};
			ccol = '{cl, cr, cr, cl};
		endfunction

		// Apply a write, or predict the answer to a query
		function void note_request(grid_req_t it);
			int          crow[4], ccol[4];
			longint      t, u, sum, cnt, mean, acc;
			longint      v[4];
			bit [16:0]   c;
			ice_result_t r;
			if (it.opcode == OP_WRITE) begin
				if (it.row < NROWS && it.col < NCOLS)
					cells[int'(it.row) * NCOLS + int'(it.col)] = {it.missing, it.value};
				return;
			end
			r = '{frac: 16'd0, flag: 1'b0, no_data: 1'b1};
			if (grid_on) begin
				locate(it.lon, it.lat, crow, ccol, t, u);
				sum = 0;
				cnt = 0;
				for (int k = 0; k < 4; k++) begin
					c = cells[crow[k] * NCOLS + ccol[k]];
					v[k] = c[15:0];
					if (!c[16]) begin
						sum += c[15:0];
						cnt++;
					end
				end
				r.no_data = 1'b0;
				if (cnt > 0) begin
					mean = sum / cnt;
					// fill missing corners with the mean of the valid ones
					for (int k = 0; k < 4; k++)
						if (cells[crow[k] * NCOLS + ccol[k]][16]) v[k] = mean;
					acc = (256 - t) * (256 - u) * v[0] + t * (256 - u) * v[1]
						+ t * u * v[2] + (256 - t) * u * v[3];
					r.frac = acc[31:16];
				end
				r.flag = r.frac > threshold;
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [15:0] frac, logic flag, logic no_data);
			ice_result_t x;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with none expected: frac %0d flag %0b no_data %0b",
						frac, flag, no_data);
				return;
			end
			x = expected_q.pop_front();
			if (frac !== x.frac || flag !== x.flag || no_data !== x.no_data) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected frac %0d flag %0b no_data %0b, ",
						"got frac %0d flag %0b no_data %0b"},
						x.frac, x.flag, x.no_data, frac, flag, no_data);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_data;

	gbgfi_req_if req_if ();
	gbgfi_rsp_if rsp_if ();

	grid_bilinear_gap_fill_interp_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_if.sink),
		.rsp      (rsp_if.source)
	);

	ice_grid_scoreboard sb = new();
	bit  send_idle;
	bit  recv_idle;
	bit  hold_off;
	int  n_sent;
	int  stall_cycles;
	int  written_q[$];
	logic signed [18:0] hot_lon[$];
	logic signed [17:0] hot_lat[$];

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Known values on every input from time zero
	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= '0;
		req_if.valid <= 1'b0;
		req_if.opcode <= OP_WRITE;
		req_if.cell_row <= '0;
		req_if.cell_col <= '0;
		req_if.cell_value <= '0;
		req_if.cell_missing <= 1'b0;
		req_if.query_lon <= '0;
		req_if.query_lat <= '0;
		rsp_if.ready <= 1'b0;
	end

	// Check every accepted result
	always @(posedge clk)
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.cover_frac, rsp_if.ice_flag, rsp_if.no_data);

	// Stall watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIM) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result receiver: random back-pressure and one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_off = 1'b0;
			end
			gap = recv_idle ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	// Offer one request and hold it until accepted
	task automatic send_request(input grid_req_t it);
		int gap;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.opcode <= it.opcode;
		req_if.cell_row <= it.row;
		req_if.cell_col <= it.col;
		req_if.cell_value <= it.value;
		req_if.cell_missing <= it.missing;
		req_if.query_lon <= it.lon;
		req_if.query_lat <= it.lat;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(it);
		n_sent++;
	endtask

	task automatic write_cell(input int row, input int col, input logic [15:0] v,
			input logic m);
		grid_req_t it;
		it.opcode = OP_WRITE;
		it.row = 10'(row);
		it.col = 11'(col);
		it.value = v;
		it.missing = m;
		it.lon = 19'($urandom());
		it.lat = 18'($urandom());
		if (row < NROWS && col < NCOLS)
			written_q.push_back(row * NCOLS + col);
		send_request(it);
	endtask

	task automatic send_query(input logic signed [18:0] lon, input logic signed [17:0] lat);
		grid_req_t it;
		it.opcode = OP_QUERY;
		it.row = 10'($urandom());
		it.col = 11'($urandom());
		it.value = 16'($urandom());
		it.missing = 1'($urandom());
		it.lon = lon;
		it.lat = lat;
		send_request(it);
	endtask

	function automatic logic [15:0] rand_fraction();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(32769, 65535));
		return 16'($urandom_range(0, 32768));
	endfunction

	// Query a point, first loading any corner cell never written
	task automatic query_at(input logic signed [18:0] lon, input logic signed [17:0] lat);
		int     crow[4], ccol[4];
		longint t, u;
		sb.locate(lon, lat, crow, ccol, t, u);
		for (int k = 0; k < 4; k++)
			if (!sb.cells.exists(crow[k] * NCOLS + ccol[k]))
				write_cell(crow[k], ccol[k], rand_fraction(), $urandom_range(0, 3) == 0);
		send_query(lon, lat);
		hot_lon.push_back(lon);
		hot_lat.push_back(lat);
		if (hot_lon.size() > 64) begin
			void'(hot_lon.pop_front());
			void'(hot_lat.pop_front());
		end
	endtask

	// Load all four corners with a chosen missing pattern, then query
	task automatic query_pattern(input logic signed [18:0] lon, input logic signed [17:0] lat,
			input logic [3:0] miss, input logic [15:0] v);
		int     crow[4], ccol[4];
		longint t, u;
		sb.locate(lon, lat, crow, ccol, t, u);
		for (int k = 0; k < 4; k++)
			write_cell(crow[k], ccol[k], v + 16'(k * 1000), miss[k]);
		query_at(lon, lat);
	endtask

	// Wait for every expected result, then let the pipeline empty
	task automatic drain();
		req_if.valid <= 1'b0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [15:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_register(idx, d);
	endtask

	// Random mix: mostly queries, rewrites of loaded cells and some noise
	task automatic run_random(input int count);
		int stop, sel, i, a;
		logic signed [18:0] lon;
		logic signed [17:0] lat;
		stop = n_sent + count;
		i = 0;
		while (n_sent < stop) begin
			if (i % 64 == 0) begin
				send_idle = $urandom_range(0, 3) != 0;
				recv_idle = $urandom_range(0, 3) != 0;
			end
			i++;
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				if (hot_lon.size() > 0 && $urandom_range(0, 1) == 0) begin
					a = $urandom_range(0, hot_lon.size() - 1);
					lon = hot_lon[a] + 19'($urandom_range(0, 4096)) - 19'sd2048;
					lat = hot_lat[a] + 18'($urandom_range(0, 2048)) - 18'sd1024;
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2:  lon = 19'($urandom());
						default: lon = 19'($urandom_range(0, 368640)) - 19'sd184320;
					endcase
					case ($urandom_range(0, 9))
						0, 1:    lat = 18'($urandom());
						2, 3:    lat = ($urandom_range(0, 1) ? 18'sd92160 : -18'sd92160)
							+ 18'($urandom_range(0, 512)) - 18'sd256;
						default: lat = 18'($urandom_range(0, 184320)) - 18'sd92160;
					endcase
				end
				query_at(lon, lat);
			end else if (sel < 85 && written_q.size() > 0) begin
				a = written_q[$urandom_range(0, written_q.size() - 1)];
				write_cell(a / NCOLS, a % NCOLS, rand_fraction(), $urandom_range(0, 9) < 3);
			end else if (sel < 95) begin
				write_cell($urandom_range(0, NROWS - 1), $urandom_range(0, NCOLS - 1),
					rand_fraction(), $urandom_range(0, 3) == 0);
			end else if ($urandom_range(0, 1)) begin
				write_cell($urandom_range(NROWS, 1023), $urandom_range(0, 2047),
					16'($urandom()), 1'($urandom()));
			end else begin
				write_cell($urandom_range(0, 1023), $urandom_range(NCOLS, 2047),
					16'($urandom()), 1'($urandom()));
			end
		end
	endtask

	// Stimulus sequence
	initial begin
		logic [15:0] thr_set[5];
		thr_set = '{16'd0, 16'd65535, 16'd32768, 16'($urandom_range(1, 32767)), 16'd1};
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_off = 1'b0;
		n_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Grid not ready: queries answer no data; out-of-range writes dropped
		write_register(CFG_THRESHOLD, 16'd0);
		write_register(CFG_GRID_READY, 16'd0);
		write_cell(1023, 2047, 16'hFFFF, 1'b0);
		write_cell(NROWS, 0, 16'd100, 1'b1);
		query_at(19'sd0, 18'sd0);
		query_at(-19'sd184320, 18'sd92160);
		drain();

		// Directed corner cases with the grid ready
		write_register(CFG_GRID_READY, 16'd1);
		write_register(CFG_THRESHOLD, 16'd16384);
		query_pattern(-19'sd184320, -18'sd92160, 4'b0000, 16'd1000);
		query_pattern(19'sd262143, 18'sd131071, 4'b1111, 16'd20000);
		query_pattern(19'sd0, 18'sd0, 4'b0010, 16'd30000);
		query_pattern(-19'sd262144, -18'sd131072, 4'b0101, 16'd65535);
		query_pattern(19'sd184320, 18'sd92160, 4'b0000, 16'd32768);
		drain();

		// Random phases across thresholds; the third one starts with a long hold-off
		for (int ph = 0; ph < 5; ph++) begin
			write_register(CFG_THRESHOLD, thr_set[ph]);
			write_register(CFG_GRID_READY, 16'd1);
			if (ph == 2) begin
				send_idle = 1'b0;
				hold_off = 1'b1;
				repeat (40) query_at(19'($urandom()), 18'($urandom()));
			end
			run_random(310);
			drain();
		end

		// Grid switched off again
		write_register(CFG_GRID_READY, 16'd0);
		run_random(60);
		drain();

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
